>>> hdl/timer_schedule_string_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Timer schedule string parser assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TIMER_SCHEDULE_STRING_PARSER_UNIT_ASSERT_SVH
`define TIMER_SCHEDULE_STRING_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TSSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the timer string parser");
`define TSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the timer string parser");
`else
`define TSSP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/tssp_pkg.sv
// ----------------------------------------------------------------------------
// Timer schedule string parser package
// Widths, character codes and digit weights shared by the parser.
// ----------------------------------------------------------------------------
package tssp_pkg;

    localparam int CH_W     = 8;
    localparam int USER_W   = 4;
    localparam int MIN_W    = 13;
    localparam int OUT_W    = 32;
    localparam int DAY_W    = 3;

    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    localparam logic [DAY_W-1:0] DAYS_PER_WEEK = 3'd7;
    localparam logic [DAY_W-1:0] LAST_WEEKDAY  = 3'd6;

    localparam logic [MIN_W-1:0] WEIGHT_TEN_HOURS   = 13'd600;
    localparam logic [MIN_W-1:0] WEIGHT_HOUR        = 13'd60;
    localparam logic [MIN_W-1:0] WEIGHT_TEN_MINUTES = 13'd10;

    typedef struct packed {
        logic             en;
        logic [MIN_W-1:0] minutes;
    } t_time;

    localparam t_time TIME_OFF = '{en: 1'b0, minutes: '0};

endpackage

>>> hdl/timer_schedule_string_parser_unit.sv
// ----------------------------------------------------------------------------
// Timer schedule string parser
// Parses a daily or weekly shutter timer string and reports one day's times.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and reports, after the character
// flagged by tlast, the up and down minutes with enable flags for the
// selected day (entry 0 for a daily string, the Monday-based weekday for a
// weekly one). Each character passes an input register and one stage of
// parse logic, whose digit weighting by 600, 60 and 10 sets the path length;
// the result is written to the output register when the parse logic takes
// in its last character. A new character is accepted every cycle unless a
// finished result waits in the output register while a further last
// character is pending. Parse state returns to reset after every string.

module timer_schedule_string_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // ch [7:0]
    input  logic [tssp_pkg::CH_W-1:0]     s_axis_tdata,
    // is_weekly [0], week_day [3:1]
    input  logic [tssp_pkg::USER_W-1:0]   s_axis_tuser,
    // last_char
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // up_minutes [12:0], up_enabled [13], down_minutes [26:14],
    // down_enabled [27], zero [31:28]
    output logic [tssp_pkg::OUT_W-1:0]    m_axis_tdata
);

    import tssp_pkg::*;

    `include "timer_schedule_string_parser_unit_assert.svh"

    logic               r_in_valid;
    logic [CH_W-1:0]    r_in_ch;
    logic               r_in_weekly;
    logic [DAY_W-1:0]   r_in_wday;
    logic               r_in_last;

    logic               r_phase;
    logic               n_phase;
    logic [1:0]         r_digit_pos;
    logic [1:0]         n_digit_pos;
    logic [MIN_W-1:0]   r_partial;
    logic [MIN_W-1:0]   n_partial;
    t_time              r_held_up;
    t_time              n_held_up;
    t_time              r_held_down;
    t_time              n_held_down;
    logic [DAY_W-1:0]   r_day_count;
    logic [DAY_W-1:0]   n_day_count;
    logic               r_day_captured;
    logic               n_day_captured;
    t_time              r_cap_up;
    t_time              n_cap_up;
    t_time              r_cap_down;
    t_time              n_cap_down;

    logic               r_out_valid;
    logic               n_out_valid;
    t_time              r_out_up;
    t_time              n_out_up;
    t_time              r_out_down;
    t_time              n_out_down;

    logic               in_adv;
    logic [DAY_W-1:0]   target;
    logic [3:0]         digit;
    logic [MIN_W-1:0]   digit_term;
    logic               field_done;
    logic               entry_done;
    t_time              field_val;

    assign in_adv        = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || in_adv;

    always_comb begin
        if (!r_in_weekly) begin
            target = '0;
        end else if (r_in_wday == '0) begin
            target = LAST_WEEKDAY;
        end else begin
            target = r_in_wday - 3'd1;
        end
        if (r_in_ch >= CH_ZERO && r_in_ch <= CH_NINE) begin
            digit = 4'(r_in_ch - CH_ZERO);
        end else begin
            digit = '0;
        end
        case (r_digit_pos)
            2'd0:    digit_term = MIN_W'(digit) * WEIGHT_TEN_HOURS;
            2'd1:    digit_term = MIN_W'(digit) * WEIGHT_HOUR;
            2'd2:    digit_term = MIN_W'(digit) * WEIGHT_TEN_MINUTES;
            default: digit_term = MIN_W'(digit);
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_digit_pos    = r_digit_pos;
        n_partial      = r_partial;
        n_held_up      = r_held_up;
        n_held_down    = r_held_down;
        n_day_count    = r_day_count;
        n_day_captured = r_day_captured;
        n_cap_up       = r_cap_up;
        n_cap_down     = r_cap_down;
        n_out_up       = r_out_up;
        n_out_down     = r_out_down;
        n_out_valid    = r_out_valid && !m_axis_tready;
        field_done     = 1'b0;
        entry_done     = 1'b0;
        field_val      = TIME_OFF;

        if (in_adv && !r_day_captured && r_day_count < DAYS_PER_WEEK) begin
            if (!r_phase && r_digit_pos == '0 && r_day_count != '0
                    && r_in_ch == CH_PLUS) begin
                entry_done = 1'b1;
            end else if (r_digit_pos == '0 && r_in_ch == CH_MINUS) begin
                field_done = 1'b1;
            end else if (r_digit_pos == 2'd3) begin
                field_done = 1'b1;
                field_val  = '{en: 1'b1, minutes: r_partial + digit_term};
            end else begin
                n_digit_pos = r_digit_pos + 2'd1;
                n_partial   = (r_digit_pos == '0) ? digit_term : r_partial + digit_term;
            end
        end

        if (field_done) begin
            if (!r_phase) begin
                n_held_up = field_val;
                n_phase   = 1'b1;
            end else begin
                n_held_down = field_val;
                n_phase     = 1'b0;
                entry_done  = 1'b1;
            end
            n_digit_pos = '0;
            n_partial   = '0;
        end

        if (entry_done) begin
            if (r_day_count == target) begin
                n_day_captured = 1'b1;
                n_cap_up       = n_held_up;
                n_cap_down     = n_held_down;
            end
            if (r_day_count < DAYS_PER_WEEK) begin
                n_day_count = r_day_count + 3'd1;
            end
        end

        if (in_adv && r_in_last) begin
            n_out_valid    = 1'b1;
            n_out_up       = n_day_captured ? n_cap_up : TIME_OFF;
            n_out_down     = n_day_captured ? n_cap_down : TIME_OFF;
            n_phase        = 1'b0;
            n_digit_pos    = '0;
            n_partial      = '0;
            n_held_up      = TIME_OFF;
            n_held_down    = TIME_OFF;
            n_day_count    = '0;
            n_day_captured = 1'b0;
            n_cap_up       = TIME_OFF;
            n_cap_down     = TIME_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= 1'b0;
            r_digit_pos    <= '0;
            r_partial      <= '0;
            r_held_up      <= TIME_OFF;
            r_held_down    <= TIME_OFF;
            r_day_count    <= '0;
            r_day_captured <= 1'b0;
            r_cap_up       <= TIME_OFF;
            r_cap_down     <= TIME_OFF;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_out_valid    <= n_out_valid;
            r_phase        <= n_phase;
            r_digit_pos    <= n_digit_pos;
            r_partial      <= n_partial;
            r_held_up      <= n_held_up;
            r_held_down    <= n_held_down;
            r_day_count    <= n_day_count;
            r_day_captured <= n_day_captured;
            r_cap_up       <= n_cap_up;
            r_cap_down     <= n_cap_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch     <= s_axis_tdata;
            r_in_weekly <= s_axis_tuser[0];
            r_in_wday   <= s_axis_tuser[3:1];
            r_in_last   <= s_axis_tlast;
        end
        r_out_up   <= n_out_up;
        r_out_down <= n_out_down;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_down.en, r_out_down.minutes,
                            r_out_up.en, r_out_up.minutes};

    `TSSP_ASSERT_SAME(a_capture_counts_day, i_clk, i_rst_n, r_day_captured, r_day_count != '0)
    `TSSP_ASSERT_SAME(a_no_digits_after_capture, i_clk, i_rst_n, r_digit_pos != '0, !r_day_captured)
    `TSSP_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, in_adv && r_in_last,
        r_day_count == '0 && !r_day_captured && r_digit_pos == '0 && r_out_valid)

endmodule
